// ===== sv/ecau_pkg.sv =====
package ecau_pkg;

   // operation codes on req_type
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_RECIP = 3'd4;
   localparam logic [2:0] OP_SQR   = 3'd5;
   localparam logic [2:0] OP_CONJ  = 3'd6;
   localparam logic [2:0] OP_NEG   = 3'd7;

   // quotient too large for the low quotient bits
   typedef struct packed {
      logic big_re;
      logic big_im;
   } div_flags_type;

endpackage

// ===== sv/ecau_div_pipe.sv =====
module ecau_div_pipe #(
   parameter int QW  = 32,
   parameter int NW  = 97,
   parameter int DW  = 65,
   parameter int SBW = 69
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ce,
   input  logic                        in_valid,
   input  logic [NW-1:0]               in_num_re,
   input  logic [NW-1:0]               in_num_im,
   input  logic [DW-1:0]               in_den,
   input  logic [SBW-1:0]              in_side,
   output logic                        out_valid,
   output logic [QW-1:0]               out_q_re,
   output logic [QW-1:0]               out_q_im,
   output ecau_pkg::div_flags_type     out_flags,
   output logic [SBW-1:0]              out_side
);
   import ecau_pkg::*;

   localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   logic                valid_ff [0:QW];
   logic [RW-1:0]       rre_ff   [0:QW];
   logic [RW-1:0]       rim_ff   [0:QW];
   logic [QW-1:0]       qre_ff   [0:QW];
   logic [QW-1:0]       qim_ff   [0:QW];
   logic [DW-1:0]       d_ff     [0:QW];
   logic [SBW-1:0]      side_ff  [0:QW];
   div_flags_type       flags_ff [0:QW];

   logic [RW-1:0]       dtop_in;
   div_flags_type       flags_in;

   // overflow check against the divisor shifted past all quotient bits
   always_comb begin
      dtop_in         = RW'(in_den) << QW;
      flags_in.big_re = RW'(in_num_re) >= dtop_in;
      flags_in.big_im = RW'(in_num_im) >= dtop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (ce) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rre_ff[0]   <= RW'(in_num_re);
         rim_ff[0]   <= RW'(in_num_im);
         qre_ff[0]   <= '0;
         qim_ff[0]   <= '0;
         d_ff[0]     <= in_den;
         side_ff[0]  <= in_side;
         flags_ff[0] <= flags_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_bit
      localparam int SH = QW - 1 - k;
      logic [RW-1:0] dsh_in;
      logic          ge_re_in;
      logic          ge_im_in;

      always_comb begin
         dsh_in   = RW'(d_ff[k]) << SH;
         ge_re_in = rre_ff[k] >= dsh_in;
         ge_im_in = rim_ff[k] >= dsh_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (ce) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rre_ff[k+1]   <= ge_re_in ? rre_ff[k] - dsh_in : rre_ff[k];
            rim_ff[k+1]   <= ge_im_in ? rim_ff[k] - dsh_in : rim_ff[k];
            qre_ff[k+1]   <= qre_ff[k] | (QW'(ge_re_in) << SH);
            qim_ff[k+1]   <= qim_ff[k] | (QW'(ge_im_in) << SH);
            d_ff[k+1]     <= d_ff[k];
            side_ff[k+1]  <= side_ff[k];
            flags_ff[k+1] <= flags_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_q_re  = qre_ff[QW];
   assign out_q_im  = qim_ff[QW];
   assign out_flags = flags_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

// ===== sv/extended_complex_arith_unit.sv =====
// channel  direction  handshake                 payload
// req      in         req_valid / req_ready     req_type, req_a_*, req_b_*
// rsp      out        rsp_valid / rsp_ready     rsp_r_re, rsp_r_im, rsp_r_inf, rsp_overflow
//
// one transfer per cycle in and out while the output register is empty or taken;
// the divider resolves one quotient bit per stage
// all stages advance together whenever the output register is empty or taken
// synchronous reset clears the valid bits only; data registers are not reset
module extended_complex_arith_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_type,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic                         req_a_inf,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   input  logic                         req_b_inf,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_r_re,
   output logic signed [DATA_WIDTH-1:0] rsp_r_im,
   output logic                         rsp_r_inf,
   output logic                         rsp_overflow
);
   import ecau_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;          // product width
   localparam int SW  = 2 * W + 2;      // sum width
   localparam int NW  = ((2 * W + F > W + 2 * F) ? 2 * W + F : W + 2 * F) + 1;
   localparam int NSW = NW + 1;         // signed numerator
   localparam int DW  = 2 * W + 1;      // divisor magnitude
   localparam int SBW = 2 * W + 5;      // side band through the divider

   localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
   // 1.0, or the largest value when 1.0 does not fit
   localparam logic [W-1:0] ONE_V = (F >= W - 1) ? MAX_V : (W'(1) << F);

   logic ce;

   // global advance: output register empty or being drained
   assign ce        = !rsp_valid || rsp_ready;
   assign req_ready = ce;

   // ---------------- stage 0: operand registers ----------------
   logic                v0_ff;
   logic [2:0]          op0_ff;
   logic signed [W-1:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;
   logic                ainf0_ff, binf0_ff;
   logic                sqr_in;

   assign sqr_in = req_type == OP_SQR;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (ce) begin
         v0_ff <= req_valid;
      end
   end

   // square is a times a
   always_ff @(posedge clock) begin
      if (ce) begin
         op0_ff   <= req_type;
         ar0_ff   <= req_a_re;
         ai0_ff   <= req_a_im;
         ainf0_ff <= req_a_inf;
         br0_ff   <= sqr_in ? req_a_re  : req_b_re;
         bi0_ff   <= sqr_in ? req_a_im  : req_b_im;
         binf0_ff <= sqr_in ? req_a_inf : req_b_inf;
      end
   end

   // ---------------- stage 1: products ----------------
   logic                 v1_ff;
   logic [2:0]           op1_ff;
   logic signed [W-1:0]  ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic                 ainf1_ff, binf1_ff;
   logic signed [PW-1:0] prr1_ff, pii1_ff, pri1_ff, pir1_ff, sq1_ff, sq2_ff;
   logic signed [W-1:0]  xr_in, xi_in;

   // divisor squares come from a for the reciprocal, from b otherwise
   assign xr_in = (op0_ff == OP_RECIP) ? ar0_ff : br0_ff;
   assign xi_in = (op0_ff == OP_RECIP) ? ai0_ff : bi0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         op1_ff   <= op0_ff;
         ar1_ff   <= ar0_ff;
         ai1_ff   <= ai0_ff;
         br1_ff   <= br0_ff;
         bi1_ff   <= bi0_ff;
         ainf1_ff <= ainf0_ff;
         binf1_ff <= binf0_ff;
         prr1_ff  <= PW'(ar0_ff) * PW'(br0_ff);
         pii1_ff  <= PW'(ai0_ff) * PW'(bi0_ff);
         pri1_ff  <= PW'(ar0_ff) * PW'(bi0_ff);
         pir1_ff  <= PW'(ai0_ff) * PW'(br0_ff);
         sq1_ff   <= PW'(xr_in) * PW'(xr_in);
         sq2_ff   <= PW'(xi_in) * PW'(xi_in);
      end
   end

   // ---------------- stage 2: sums and special cases ----------------
   logic                 v2_ff;
   logic [2:0]           op2_ff;
   logic signed [W-1:0]  ar2_ff, ai2_ff;
   logic signed [SW-1:0] dre2_ff, dim2_ff, nre2_ff, nim2_ff, den2_ff;
   logic                 enc_inf2_ff, neg_inf2_ff, use_div2_ff;

   logic signed [SW-1:0] dre_in, dim_in, msub_in, madd_in;
   logic                 enc_inf_in, neg_inf_in, use_div_in;
   logic                 az_in, bz_in;

   always_comb begin
      msub_in    = SW'(prr1_ff) - SW'(pii1_ff);
      madd_in    = SW'(pri1_ff) + SW'(pir1_ff);
      az_in      = (ar1_ff == '0) && (ai1_ff == '0);
      bz_in      = (br1_ff == '0) && (bi1_ff == '0);
      dre_in     = '0;
      dim_in     = '0;
      enc_inf_in = 1'b0;
      neg_inf_in = 1'b0;
      use_div_in = 1'b0;
      case (op1_ff)
         OP_ADD: begin
            dre_in     = SW'(ar1_ff) + SW'(br1_ff);
            dim_in     = SW'(ai1_ff) + SW'(bi1_ff);
            enc_inf_in = ainf1_ff || binf1_ff;
         end
         OP_SUB: begin
            dre_in     = SW'(ar1_ff) - SW'(br1_ff);
            dim_in     = SW'(ai1_ff) - SW'(bi1_ff);
            enc_inf_in = ainf1_ff || binf1_ff;
         end
         OP_MUL, OP_SQR: begin
            // floor of the exact product
            dre_in     = msub_in >>> F;
            dim_in     = madd_in >>> F;
            enc_inf_in = ainf1_ff || binf1_ff;
         end
         OP_DIV: begin
            // zero divisor wins, then infinite divisor gives zero
            if (!binf1_ff && bz_in) begin
               enc_inf_in = 1'b1;
            end else if (binf1_ff) begin
               enc_inf_in = 1'b0;
            end else if (ainf1_ff) begin
               enc_inf_in = 1'b1;
            end else begin
               use_div_in = 1'b1;
            end
         end
         OP_RECIP: begin
            if (ainf1_ff) begin
               enc_inf_in = 1'b0;
            end else if (az_in) begin
               enc_inf_in = 1'b1;
            end else begin
               use_div_in = 1'b1;
            end
         end
         OP_CONJ: begin
            dre_in     = SW'(ar1_ff);
            dim_in     = -SW'(ai1_ff);
            enc_inf_in = ainf1_ff;
         end
         OP_NEG: begin
            // flag passes through, parts negate even at infinity
            dre_in     = -SW'(ar1_ff);
            dim_in     = -SW'(ai1_ff);
            neg_inf_in = ainf1_ff;
         end
         default: begin
            dre_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ce) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         op2_ff      <= op1_ff;
         ar2_ff      <= ar1_ff;
         ai2_ff      <= ai1_ff;
         dre2_ff     <= dre_in;
         dim2_ff     <= dim_in;
         nre2_ff     <= SW'(prr1_ff) + SW'(pii1_ff);
         nim2_ff     <= SW'(pir1_ff) - SW'(pri1_ff);
         den2_ff     <= SW'(sq1_ff) + SW'(sq2_ff);
         enc_inf2_ff <= enc_inf_in;
         neg_inf2_ff <= neg_inf_in;
         use_div2_ff <= use_div_in;
      end
   end

   // ---------------- stage 3: saturation and dividend magnitudes ----------------
   logic                v3_ff;
   logic                use_div3_ff, neg_re3_ff, neg_im3_ff;
   logic                finf3_ff, fovf3_ff;
   logic [W-1:0]        fre3_ff, fim3_ff;
   logic [NW-1:0]       num_re3_ff, num_im3_ff;
   logic [DW-1:0]       den3_ff;

   logic signed [NSW-1:0] sre_in, sim_in;
   logic                  re_fit_in, im_fit_in;
   logic [W-1:0]          sat_re_in, sat_im_in;

   always_comb begin
      if (op2_ff == OP_RECIP) begin
         sre_in = NSW'(ar2_ff) <<< (2 * F);
         sim_in = -(NSW'(ai2_ff) <<< (2 * F));
      end else begin
         sre_in = NSW'(nre2_ff) <<< F;
         sim_in = NSW'(nim2_ff) <<< F;
      end
      // in range when all bits above the sign agree
      re_fit_in = (&dre2_ff[SW-1:W-1]) || !(|dre2_ff[SW-1:W-1]);
      im_fit_in = (&dim2_ff[SW-1:W-1]) || !(|dim2_ff[SW-1:W-1]);
      sat_re_in = re_fit_in ? dre2_ff[W-1:0] : (dre2_ff[SW-1] ? MIN_V : MAX_V);
      sat_im_in = im_fit_in ? dim2_ff[W-1:0] : (dim2_ff[SW-1] ? MIN_V : MAX_V);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ce) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         use_div3_ff <= use_div2_ff;
         neg_re3_ff  <= sre_in[NSW-1];
         neg_im3_ff  <= sim_in[NSW-1];
         num_re3_ff  <= sre_in[NSW-1] ? NW'(-sre_in) : NW'(sre_in);
         num_im3_ff  <= sim_in[NSW-1] ? NW'(-sim_in) : NW'(sim_in);
         den3_ff     <= DW'(den2_ff);
         finf3_ff    <= enc_inf2_ff || neg_inf2_ff;
         if (enc_inf2_ff) begin
            fre3_ff  <= ONE_V;
            fim3_ff  <= '0;
            fovf3_ff <= 1'b0;
         end else begin
            fre3_ff  <= sat_re_in;
            fim3_ff  <= sat_im_in;
            fovf3_ff <= !re_fit_in || !im_fit_in;
         end
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic               dv_valid;
   logic [W-1:0]       dv_q_re, dv_q_im;
   div_flags_type      dv_flags;
   logic [SBW-1:0]     dv_side;
   logic               o_use_div, o_neg_re, o_neg_im, o_inf, o_ovf;
   logic [W-1:0]       o_re, o_im;

   ecau_div_pipe #(
      .QW  (W),
      .NW  (NW),
      .DW  (DW),
      .SBW (SBW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (v3_ff),
      .in_num_re (num_re3_ff),
      .in_num_im (num_im3_ff),
      .in_den    (den3_ff),
      .in_side   ({use_div3_ff, neg_re3_ff, neg_im3_ff, finf3_ff, fovf3_ff,
                   fre3_ff, fim3_ff}),
      .out_valid (dv_valid),
      .out_q_re  (dv_q_re),
      .out_q_im  (dv_q_im),
      .out_flags (dv_flags),
      .out_side  (dv_side)
   );

   assign {o_use_div, o_neg_re, o_neg_im, o_inf, o_ovf, o_re, o_im} = dv_side;

   // ---------------- output stage: sign and saturate the quotients ----------------
   logic [W-1:0] qre_in, qim_in;
   logic         qre_ovf_in, qim_ovf_in;

   always_comb begin
      if (o_neg_re) begin
         qre_ovf_in = dv_flags.big_re || (dv_q_re[W-1] && (|dv_q_re[W-2:0]));
         qre_in     = qre_ovf_in ? MIN_V : -dv_q_re;
      end else begin
         qre_ovf_in = dv_flags.big_re || dv_q_re[W-1];
         qre_in     = qre_ovf_in ? MAX_V : dv_q_re;
      end
      if (o_neg_im) begin
         qim_ovf_in = dv_flags.big_im || (dv_q_im[W-1] && (|dv_q_im[W-2:0]));
         qim_in     = qim_ovf_in ? MIN_V : -dv_q_im;
      end else begin
         qim_ovf_in = dv_flags.big_im || dv_q_im[W-1];
         qim_in     = qim_ovf_in ? MAX_V : dv_q_im;
      end
   end

   logic         rsp_valid_ff;
   logic [W-1:0] rsp_re_ff, rsp_im_ff;
   logic         rsp_inf_ff, rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         if (o_use_div) begin
            rsp_re_ff  <= qre_in;
            rsp_im_ff  <= qim_in;
            rsp_inf_ff <= 1'b0;
            rsp_ovf_ff <= qre_ovf_in || qim_ovf_in;
         end else begin
            rsp_re_ff  <= o_re;
            rsp_im_ff  <= o_im;
            rsp_inf_ff <= o_inf;
            rsp_ovf_ff <= o_ovf;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_r_re     = rsp_re_ff;
   assign rsp_r_im     = rsp_im_ff;
   assign rsp_r_inf    = rsp_inf_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

// ===== dv/tb_extended_complex_arith_unit.sv =====
`timescale 1ns / 1ps

module tb_extended_complex_arith_unit;
   import ecau_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int NUM_RANDOM = 1830;
   localparam int QUIET_FROM = 1500;  // last stretch of random items runs without idling
   localparam int DRAIN_CYCLES = DW + 20;

   // wide signed intermediate, large enough for every exact product and shifted numerator
   typedef logic signed [159:0] wint_type;

   typedef struct {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      logic          inf;
      logic          ovf;
   } cplx_result_type;

   // scoreboard: predicts each accepted operation and checks results in order
   class arith_scoreboard;
      cplx_result_type expected_q[$];
      int              fail_count;

      function new();
         fail_count = 0;
      endfunction

      // saturate to the DW-bit signed range
      function logic [DW-1:0] clamp(wint_type v, ref logic ovf);
         wint_type maxv;
         wint_type minv;
         maxv = (wint_type'(1) <<< (DW - 1)) - 1;
         minv = -maxv - 1;
         if (v > maxv) begin
            ovf = 1'b1;
            return maxv[DW-1:0];
         end
         if (v < minv) begin
            ovf = 1'b1;
            return minv[DW-1:0];
         end
         return v[DW-1:0];
      endfunction

      function void note(logic [2:0] op, logic signed [DW-1:0] a_re,
                         logic signed [DW-1:0] a_im, logic a_inf,
                         logic signed [DW-1:0] b_re, logic signed [DW-1:0] b_im,
                         logic b_inf);
         wint_type ar, ai, br, bi, re, im, den;
         logic to_inf;
         logic ovf;
         cplx_result_type r;
         ar = wint_type'(a_re);
         ai = wint_type'(a_im);
         br = wint_type'(b_re);
         bi = wint_type'(b_im);
         re = 0;
         im = 0;
         to_inf = 1'b0;
         ovf = 1'b0;
         // square is a multiply of a by itself
         if (op == OP_SQR) begin
            br = ar;
            bi = ai;
            b_inf = a_inf;
         end
         case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_SQR, OP_CONJ: begin
               if (a_inf || (op != OP_CONJ && b_inf)) to_inf = 1'b1;
               else if (op == OP_ADD) begin
                  re = ar + br;
                  im = ai + bi;
               end else if (op == OP_SUB) begin
                  re = ar - br;
                  im = ai - bi;
               end else if (op == OP_CONJ) begin
                  re = ar;
                  im = -ai;
               end else begin
                  // floor of the exact product
                  re = (ar * br - ai * bi) >>> FB;
                  im = (ar * bi + ai * br) >>> FB;
               end
            end
            OP_DIV: begin
               if (!b_inf && br == 0 && bi == 0) to_inf = 1'b1;
               else if (b_inf) begin
                  // anything over infinity is zero
               end else if (a_inf) to_inf = 1'b1;
               else begin
                  den = br * br + bi * bi;
                  re = ((ar * br + ai * bi) <<< FB) / den;
                  im = ((ai * br - ar * bi) <<< FB) / den;
               end
            end
            OP_RECIP: begin
               if (a_inf) begin
                  // reciprocal of infinity is zero
               end else if (ar == 0 && ai == 0) to_inf = 1'b1;
               else begin
                  den = ar * ar + ai * ai;
                  re = (ar <<< (2 * FB)) / den;
                  im = ((-ai) <<< (2 * FB)) / den;
               end
            end
            default: begin
               // negate keeps the infinity flag and still negates the parts
               re = -ar;
               im = -ai;
            end
         endcase
         if (to_inf) begin
            r.re = clamp(wint_type'(1) <<< FB, ovf);
            r.im = '0;
            r.inf = 1'b1;
            r.ovf = 1'b0;
         end else begin
            r.re = clamp(re, ovf);
            r.im = clamp(im, ovf);
            r.inf = (op == OP_NEG) ? a_inf : 1'b0;
            r.ovf = ovf;
         end
         expected_q = {expected_q, r};
      endfunction

      function void check(logic [DW-1:0] re, logic [DW-1:0] im, logic inf, logic ovf);
         cplx_result_type e;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
            return;
         end
         e = expected_q.pop_front();
         if (re !== e.re) begin
            $error("r_re expected %h actual %h", e.re, re);
            fail_count++;
         end
         if (im !== e.im) begin
            $error("r_im expected %h actual %h", e.im, im);
            fail_count++;
         end
         if (inf !== e.inf) begin
            $error("r_inf expected %b actual %b", e.inf, inf);
            fail_count++;
         end
         if (ovf !== e.ovf) begin
            $error("overflow expected %b actual %b", e.ovf, ovf);
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [2:0]           req_type;
   logic signed [DW-1:0] req_a_re;
   logic signed [DW-1:0] req_a_im;
   logic                 req_a_inf;
   logic signed [DW-1:0] req_b_re;
   logic signed [DW-1:0] req_b_im;
   logic                 req_b_inf;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [DW-1:0] rsp_r_re;
   logic signed [DW-1:0] rsp_r_im;
   logic                 rsp_r_inf;
   logic                 rsp_overflow;

   arith_scoreboard sb;
   bit              quiet;  // no idling on either side once set

   extended_complex_arith_unit #(
      .DATA_WIDTH(DW),
      .FRAC_BITS (FB)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_a_re    (req_a_re),
      .req_a_im    (req_a_im),
      .req_a_inf   (req_a_inf),
      .req_b_re    (req_b_re),
      .req_b_im    (req_b_im),
      .req_b_inf   (req_b_inf),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_r_re    (rsp_r_re),
      .rsp_r_im    (rsp_r_im),
      .rsp_r_inf   (rsp_r_inf),
      .rsp_overflow(rsp_overflow)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // result side: check every transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check(rsp_r_re, rsp_r_im, rsp_r_inf, rsp_overflow);
   end

   // result side back-pressure in random bursts
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end
      end
   end

   // hold one operation on the request side until its transfer; returns at a falling edge
   task automatic send(logic [2:0] op, logic signed [DW-1:0] a_re, logic signed [DW-1:0] a_im,
                       logic a_inf, logic signed [DW-1:0] b_re, logic signed [DW-1:0] b_im,
                       logic b_inf);
      req_valid <= 1'b1;
      req_type  <= op;
      req_a_re  <= a_re;
      req_a_im  <= a_im;
      req_a_inf <= a_inf;
      req_b_re  <= b_re;
      req_b_im  <= b_im;
      req_b_inf <= b_inf;
      do @(posedge clock); while (!req_ready);
      sb.note(op, a_re, a_im, a_inf, b_re, b_im, b_inf);
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   // mix of zero, small, mid-range, full-range and extreme values
   function automatic logic signed [DW-1:0] pick_part();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2, 3:    return DW'($urandom_range(0, 2 ** 19) - 2 ** 18);
         4, 5, 6: return DW'($urandom_range(0, 2 ** 25) - 2 ** 24);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic pick_inf();
      return $urandom_range(0, 7) == 0;
   endfunction

   localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
   localparam logic signed [DW-1:0] MINV = 32'sh80000000;
   localparam logic signed [DW-1:0] ONE  = 32'sh00010000;

   initial begin
      logic [2:0] op;
      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = OP_ADD;
      req_a_re = '0;
      req_a_im = '0;
      req_a_inf = 1'b0;
      req_b_re = '0;
      req_b_im = '0;
      req_b_inf = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every operation, extremes and every infinity / zero case
      send(OP_ADD,   MAXV, MINV, 0, MAXV, MINV, 0);          // saturate both ways
      send(OP_SUB,   MINV, MAXV, 0, ONE, -ONE, 0);
      send(OP_ADD,   ONE, ONE, 1, ONE, ONE, 0);              // infinite operand
      send(OP_SUB,   ONE, ONE, 0, ONE, ONE, 1);
      send(OP_MUL,   MINV, MINV, 0, MINV, MAXV, 0);
      send(OP_MUL,   -32'sd3, 32'sd5, 0, 32'sd7, -32'sd1, 0); // floor of negative products
      send(OP_MUL,   ONE, '0, 0, '0, '0, 1);
      send(OP_DIV,   '0, '0, 0, '0, '0, 0);                  // zero over zero
      send(OP_DIV,   ONE, ONE, 1, '0, '0, 0);                // infinity over zero
      send(OP_DIV,   ONE, ONE, 0, ONE, ONE, 1);              // finite over infinity
      send(OP_DIV,   ONE, ONE, 1, ONE, ONE, 1);              // infinity over infinity
      send(OP_DIV,   ONE, '0, 1, 32'sd3, -ONE, 0);           // infinity over finite
      send(OP_DIV,   MAXV, MINV, 0, 32'sd1, 32'sd0, 0);
      send(OP_DIV,   -ONE, 32'sd7, 0, 32'sd3 * ONE, ONE, 0);
      send(OP_RECIP, ONE, ONE, 1, '0, '0, 0);                // reciprocal of infinity
      send(OP_RECIP, '0, '0, 0, MAXV, MAXV, 1);              // reciprocal of zero
      send(OP_RECIP, 32'sd1, 32'sd0, 0, '0, '0, 0);
      send(OP_RECIP, MINV, MAXV, 0, '0, '0, 0);
      send(OP_SQR,   MAXV, MINV, 0, '0, '0, 0);
      send(OP_SQR,   ONE, ONE, 1, '0, '0, 0);
      send(OP_CONJ,  MAXV, MINV, 0, '0, '0, 1);
      send(OP_CONJ,  ONE, ONE, 1, '0, '0, 0);
      send(OP_NEG,   MINV, MAXV, 0, '0, '0, 0);
      send(OP_NEG,   ONE, MINV, 1, '0, '0, 0);               // negate keeps the flag
      req_valid <= 1'b0;

      // sender holds off until the pipeline is empty
      while (sb.pending() != 0) @(negedge clock);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == QUIET_FROM) quiet = 1'b1;
         op = 3'($urandom_range(0, 7));
         send(op, pick_part(), pick_part(), pick_inf(), pick_part(), pick_part(), pick_inf());
         maybe_idle();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("tb_extended_complex_arith_unit OK");
      end else begin
         $display("tb_extended_complex_arith_unit NOT OK");
      end
      $finish;
   end

   // run limit far beyond the slowest legal run
   initial begin
      #5ms;
      $display("tb_extended_complex_arith_unit NOT OK");
      $finish;
   end

endmodule
